// ===== rtl/skidx_pkg.sv =====
`default_nettype none
package skidx_pkg;
  localparam int unsigned MaxBlocks = 256;
  localparam int unsigned BlkW = $clog2(MaxBlocks);
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);

  localparam logic [1:0] ReqFind    = 2'd0;
  localparam logic [1:0] ReqAdd     = 2'd1;
  localparam logic [1:0] ReqDelete  = 2'd2;
  localparam logic [1:0] ReqReplace = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNotFound = 3'd1;
  localparam logic [2:0] StInUse    = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StBadArg   = 3'd4;
endpackage
`default_nettype wire

// ===== rtl/sorted_key_index_with_free_list.sv =====
// Sorted key index with a free list. Raise start with a request while busy is
// low; the beat is taken at that edge. The result sits on the result ports for
// exactly one cycle with done_o high, in the cycle in which busy falls again.
// The receiver cannot stall, so capture the beat when done_o is seen. The
// block order and the 128-bit names live in two synchronous memories with a
// registered read. After reset busy stays high while the order memory is
// loaded with the identity permutation. A request that fails early (bad size
// or full index) answers in the cycle after it is taken and busy does not
// rise. Otherwise busy stays high through a hint try when the hint is usable,
// then binary-search probes (order read, name read, compare; at most
// ceil(log2(count+1)) probes) and a closing step on a miss, then fetches of
// the block at the position and of the free-list head and a decision, and for
// an update a shift of the moved order entries, then one fix-up write (two
// for replace). Moved entries: count-position for add, size-1-position for
// delete and size-1-count for replace, so a long free list makes deletes and
// replaces slow. Names of free blocks are never read, so they are not cleared.
// Write the size register (cfg_valid_i/cfg_ready_o) only while idle.
`default_nettype none
module sorted_key_index_with_free_list (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output      logic                     cfg_ready_o,
  input  wire logic [8:0]               cfg_data_i,
  input  wire logic                     start,
  output      logic                     busy,
  input  wire logic [1:0]               req_type_i,
  input  wire logic [63:0]              name_hi_i,
  input  wire logic [63:0]              name_lo_i,
  input  wire logic                     hint_valid_i,
  input  wire logic [7:0]               hint_index_i,
  output      logic                     done_o,
  output      logic [2:0]               status_o,
  output      logic [7:0]               block_number_o,
  output      logic [8:0]               position_o,
  output      logic [8:0]               live_count_o
);
  localparam int unsigned BW = skidx_pkg::BlkW;
  localparam int unsigned CW = skidx_pkg::CntW;

  typedef enum logic [13:0] {
    S_INIT   = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_HORD   = 14'b00000000000100,
    S_HNAME  = 14'b00000000001000,
    S_HCMP   = 14'b00000000010000,
    S_ORD    = 14'b00000000100000,
    S_NAME   = 14'b00000001000000,
    S_CMP    = 14'b00000010000000,
    S_RPOS   = 14'b00000100000000,
    S_RHEAD  = 14'b00001000000000,
    S_DECIDE = 14'b00010000000000,
    S_SHIFT  = 14'b00100000000000,
    S_FIX1   = 14'b01000000000000,
    S_FIX2   = 14'b10000000000000
  } state_e;

  state_e state_q;
  logic [8:0] size_reg_q;
  logic [CW-1:0] cnt_q;
  logic [BW-1:0] init_q;

  // order permutation and names, registered synchronous read each
  logic [BW-1:0] order_mem [skidx_pkg::MaxBlocks];
  logic [BW-1:0] ord_rd_q;
  logic [127:0] name_mem [skidx_pkg::MaxBlocks];
  logic [127:0] name_rd_q;

  logic [1:0] req_q;
  logic [127:0] key_q;
  logic [7:0] hint_q;
  logic signed [CW+1:0] lo_q, hi_q;
  logic [CW-1:0] pos_q;
  logic found_q;
  logic [CW-1:0] size_q;
  logic [BW-1:0] pos_blk_q;

  // order shift engine: read one entry per cycle, write it one slot over
  logic [CW-1:0] sh_ra_q, sh_wa_q, sh_left_q;
  logic sh_up_q, sh_wv_q;
  logic [BW-1:0] fx1_a_q, fx1_d_q, fx2_a_q, fx2_d_q;
  logic fx2_en_q;

  logic [2:0] st_q;
  logic [7:0] blk_q;
  logic [8:0] opos_q;
  logic done_q;
  logic done_d;

  logic ord_re, ord_we;
  logic [BW-1:0] ord_ra, ord_wa, ord_wd;
  logic nm_re, nm_we;
  logic [BW-1:0] nm_ra, nm_wa;
  logic [127:0] nm_wd;

  logic [CW-1:0] size_eff;
  assign size_eff = (size_reg_q > 9'(skidx_pkg::MaxBlocks)) ?
                    CW'(skidx_pkg::MaxBlocks) : size_reg_q;

  logic early_bad, early_full;
  assign early_bad = (size_eff == '0) || (cnt_q > size_eff);
  assign early_full = (req_type_i == skidx_pkg::ReqAdd ||
                       req_type_i == skidx_pkg::ReqReplace) && (cnt_q == size_eff);

  logic signed [CW+1:0] mid;
  assign mid = (lo_q + hi_q) >>> 1;

  logic eq, lt;
  assign eq = (key_q == name_rd_q);
  assign lt = (key_q < name_rd_q);

  logic upd_add, upd_del, upd_rep;
  assign upd_add = (req_q == skidx_pkg::ReqAdd) && !found_q;
  assign upd_del = (req_q == skidx_pkg::ReqDelete) && found_q;
  assign upd_rep = (req_q == skidx_pkg::ReqReplace) && found_q;

  logic [CW-1:0] last_idx;
  assign last_idx = size_q - CW'(1);

  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE) && !start;
  assign done_o = done_q;
  assign status_o = st_q;
  assign block_number_o = blk_q;
  assign position_o = opos_q;
  assign live_count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (ord_we) order_mem[ord_wa] <= ord_wd;
    if (ord_re) ord_rd_q <= order_mem[ord_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nm_we) name_mem[nm_wa] <= nm_wd;
    if (nm_re) name_rd_q <= name_mem[nm_ra];
  end

  always_comb begin
    ord_re = 1'b0;
    ord_ra = '0;
    ord_we = 1'b0;
    ord_wa = '0;
    ord_wd = '0;
    case (state_q)
      S_INIT: begin
        ord_we = 1'b1;
        ord_wa = init_q;
        ord_wd = init_q;
      end
      S_HORD: begin
        ord_re = 1'b1;
        ord_ra = hint_q;
      end
      S_ORD: begin
        ord_re = (mid != lo_q);
        ord_ra = mid[BW-1:0];
      end
      S_RPOS: begin
        ord_re = 1'b1;
        ord_ra = pos_q[BW-1:0];
      end
      S_RHEAD: begin
        ord_re = 1'b1;
        ord_ra = cnt_q[BW-1:0];
      end
      S_SHIFT: begin
        ord_re = (sh_left_q != '0);
        ord_ra = sh_ra_q[BW-1:0];
        ord_we = sh_wv_q;
        ord_wa = sh_wa_q[BW-1:0];
        ord_wd = ord_rd_q;
      end
      S_FIX1: begin
        ord_we = 1'b1;
        ord_wa = fx1_a_q;
        ord_wd = fx1_d_q;
      end
      S_FIX2: begin
        ord_we = 1'b1;
        ord_wa = fx2_a_q;
        ord_wd = fx2_d_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    nm_re = 1'b0;
    nm_ra = '0;
    nm_we = 1'b0;
    nm_wa = '0;
    nm_wd = '0;
    case (state_q)
      S_HNAME, S_NAME: begin
        nm_re = 1'b1;
        nm_ra = ord_rd_q;
      end
      S_DECIDE: begin
        // the free-list head arrives now; give it the new name
        nm_we = upd_add || upd_rep;
        nm_wa = ord_rd_q;
        nm_wd = key_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    done_d = 1'b0;
    case (state_q)
      S_IDLE:   done_d = start && (early_bad || early_full);
      S_DECIDE: done_d = !(upd_add || upd_del || upd_rep);
      S_FIX1:   done_d = !fx2_en_q;
      S_FIX2:   done_d = 1'b1;
      default:  done_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      size_reg_q <= 9'd256;
      cnt_q <= '0;
      init_q <= '0;
      req_q <= skidx_pkg::ReqFind;
      key_q <= '0;
      hint_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      pos_q <= '0;
      found_q <= 1'b0;
      size_q <= '0;
      pos_blk_q <= '0;
      sh_ra_q <= '0;
      sh_wa_q <= '0;
      sh_left_q <= '0;
      sh_up_q <= 1'b0;
      sh_wv_q <= 1'b0;
      fx1_a_q <= '0;
      fx1_d_q <= '0;
      fx2_a_q <= '0;
      fx2_d_q <= '0;
      fx2_en_q <= 1'b0;
      st_q <= skidx_pkg::StOk;
      blk_q <= '0;
      opos_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (cfg_valid_i && cfg_ready_o) size_reg_q <= cfg_data_i;
      case (state_q)
        // load the identity permutation, one entry per cycle
        S_INIT: begin
          init_q <= init_q + BW'(1);
          if (init_q == BW'(skidx_pkg::MaxBlocks - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_q <= req_type_i;
            key_q <= {name_hi_i, name_lo_i};
            hint_q <= hint_index_i;
            size_q <= size_eff;
            lo_q <= '1;
            hi_q <= (CW+2)'(cnt_q);
            found_q <= 1'b0;
            pos_q <= '0;
            if (early_bad) begin
              st_q <= skidx_pkg::StBadArg; blk_q <= '0; opos_q <= '0;
            end else if (early_full) begin
              st_q <= skidx_pkg::StFull; blk_q <= '0; opos_q <= '0;
            end else if (hint_valid_i && {1'b0, hint_index_i} < cnt_q) begin
              state_q <= S_HORD;
            end else begin
              state_q <= S_ORD;
            end
          end
        end
        S_HORD:  state_q <= S_HNAME;
        S_HNAME: state_q <= S_HCMP;
        S_HCMP: begin
          if (eq) begin
            pos_q <= {1'b0, hint_q};
            found_q <= 1'b1;
            state_q <= S_RPOS;
          end else begin
            state_q <= S_ORD;
          end
        end
        // probe: order read here, name read next, compare after that; a miss closes here once mid meets lo
        S_ORD: begin
          if (mid == lo_q) begin
            pos_q <= hi_q[CW-1:0];
            state_q <= S_RPOS;
          end else begin
            state_q <= S_NAME;
          end
        end
        S_NAME: state_q <= S_CMP;
        S_CMP: begin
          if (eq) begin
            pos_q <= mid[CW-1:0];
            found_q <= 1'b1;
            state_q <= S_RPOS;
          end else begin
            if (lt) hi_q <= mid; else lo_q <= mid;
            state_q <= S_ORD;
          end
        end
        S_RPOS: state_q <= S_RHEAD;
        S_RHEAD: begin
          pos_blk_q <= ord_rd_q;
          state_q <= S_DECIDE;
        end
        // ord_rd_q holds the free-list head in this cycle
        S_DECIDE: begin
          opos_q <= pos_q;
          sh_wv_q <= 1'b0;
          fx2_en_q <= upd_rep;
          case (req_q)
            skidx_pkg::ReqFind: begin
              st_q <= found_q ? skidx_pkg::StOk : skidx_pkg::StNotFound;
              blk_q <= (pos_q < size_q) ? pos_blk_q : 8'd0;
            end
            skidx_pkg::ReqAdd: begin
              if (found_q) begin
                st_q <= skidx_pkg::StInUse;
                blk_q <= pos_blk_q;
              end else begin
                st_q <= skidx_pkg::StOk;
                blk_q <= ord_rd_q;
                cnt_q <= cnt_q + CW'(1);
                sh_up_q <= 1'b1;
                sh_ra_q <= cnt_q - CW'(1);
                sh_left_q <= cnt_q - pos_q;
                fx1_a_q <= pos_q[BW-1:0];
                fx1_d_q <= ord_rd_q;
              end
            end
            skidx_pkg::ReqDelete: begin
              if (!found_q) begin
                st_q <= skidx_pkg::StNotFound; blk_q <= '0;
              end else begin
                st_q <= skidx_pkg::StOk;
                blk_q <= pos_blk_q;
                cnt_q <= cnt_q - CW'(1);
                sh_up_q <= 1'b0;
                sh_ra_q <= pos_q + CW'(1);
                sh_left_q <= last_idx - pos_q;
                fx1_a_q <= last_idx[BW-1:0];
                fx1_d_q <= pos_blk_q;
              end
            end
            default: begin
              if (!found_q) begin
                st_q <= skidx_pkg::StNotFound; blk_q <= '0;
              end else begin
                st_q <= skidx_pkg::StOk;
                blk_q <= ord_rd_q;
                sh_up_q <= 1'b0;
                sh_ra_q <= cnt_q + CW'(1);
                sh_left_q <= last_idx - cnt_q;
                fx1_a_q <= last_idx[BW-1:0];
                fx1_d_q <= pos_blk_q;
                fx2_a_q <= pos_q[BW-1:0];
                fx2_d_q <= ord_rd_q;
              end
            end
          endcase
          if (upd_add || upd_del || upd_rep) state_q <= S_SHIFT;
          else state_q <= S_IDLE;
        end
        // read ahead of the write so every entry is read before it is overwritten
        S_SHIFT: begin
          if (sh_left_q != '0) begin
            sh_wv_q <= 1'b1;
            sh_wa_q <= sh_up_q ? sh_ra_q + CW'(1) : sh_ra_q - CW'(1);
            sh_ra_q <= sh_up_q ? sh_ra_q - CW'(1) : sh_ra_q + CW'(1);
            sh_left_q <= sh_left_q - CW'(1);
          end else begin
            sh_wv_q <= 1'b0;
            state_q <= S_FIX1;
          end
        end
        S_FIX1: state_q <= fx2_en_q ? S_FIX2 : S_IDLE;
        S_FIX2: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while busy");
  a_shift_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |=> !done_o) else $error("done during shift");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(skidx_pkg::MaxBlocks)) else $error("count above maximum");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(cnt_q)) else $error("count moved idle");
endmodule
`default_nettype wire
